/* rtl/gasp_pkg.sv */
// Shared types and constants for the grid path search block.
`timescale 1ns / 1ps

package gasp_pkg;

  localparam int COORD_W = 5;
  localparam int COST_W = 14;
  localparam int ORDER_W = 10;
  localparam int PATH_AW = 10;
  localparam int PATH_DEPTH = 1 << PATH_AW;
  localparam int EXT_W = 6;

  localparam logic [COST_W-1:0] STEP_COST = 14'd10;
  localparam logic [EXT_W-1:0] RESET_COLS = 6'd24;
  localparam logic [EXT_W-1:0] RESET_ROWS = 6'd25;

  // Register indexes on the configuration port
  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_OBSTACLE = 2'd1,
    OP_SEARCH   = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_UNSEEN = 2'd0,
    ST_OPEN   = 2'd1,
    ST_CLOSED = 2'd2
  } status_t;

  // Direction of a neighbor or of a parent, seen from the cell
  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef struct packed {
    logic               base;
    logic               temp;
    status_t            status;
    logic [COST_W-1:0]  cost;
    dir_t               parent;
    logic [ORDER_W-1:0] order;
  } cell_word_t;

  function automatic logic [COORD_W-1:0] absdiff5(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Usable extent: register value held to at least 1 and at most lim
  function automatic logic [EXT_W-1:0] clamp_ext(input logic [EXT_W-1:0] v,
                                                 input logic [EXT_W-1:0] lim);
    logic [EXT_W-1:0] r;
    r = (v == '0) ? 6'd1 : v;
    if (r > lim) r = lim;
    return r;
  endfunction

endpackage

/* rtl/grid_astar_path_search_top.sv */
// A* search on a 4-connected grid with a cell memory (map and obstacle bits) and a path memory.
// One item at a time, taken only in the idle state; its result is registered in the done state.
// A search scans the usable area of the cell memory once per expansion, then, if the target is
// reached, writes the path cell by cell from the target back to the start, and ends with a sweep
// through the cell memory that clears obstacles and search state.
// After reset a pass clears the whole cell memory; no item is taken until then.
`timescale 1ns / 1ps

module grid_astar_path_search_top #(
  parameter int GRID_COLS = 32,
  parameter int GRID_ROWS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     operation,
  input  logic [gasp_pkg::COORD_W-1:0]   col,
  input  logic [gasp_pkg::COORD_W-1:0]   row,
  input  logic                           blocked,
  input  logic [gasp_pkg::COORD_W-1:0]   target_col,
  input  logic [gasp_pkg::COORD_W-1:0]   target_row,
  input  logic [gasp_pkg::PATH_AW-1:0]   step_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           found,
  output logic [gasp_pkg::PATH_AW-1:0]   path_length,
  output logic                           step_valid,
  output logic [gasp_pkg::COORD_W-1:0]   step_col,
  output logic [gasp_pkg::COORD_W-1:0]   step_row,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [gasp_pkg::EXT_W-1:0]     cfg_data
);

  localparam int UC = (GRID_COLS < 32) ? GRID_COLS : 32;
  localparam int UR = (GRID_ROWS < 32) ? GRID_ROWS : 32;
  localparam int CW = $clog2(UC);
  localparam int RW = $clog2(UR);
  localparam int AW = CW + RW;
  localparam int DEPTH = 1 << AW;
  localparam logic [gasp_pkg::EXT_W-1:0] UC_EXT = gasp_pkg::EXT_W'(UC);
  localparam logic [gasp_pkg::EXT_W-1:0] UR_EXT = gasp_pkg::EXT_W'(UR);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_CELL_RD, S_CELL_WR, S_PATH_RD, S_SEARCH_RD, S_SEARCH_WR,
    S_SCAN, S_SCAN_D1, S_SCAN_D2, S_EXPAND, S_NB_ISSUE, S_NB_EVAL, S_CHECK,
    S_TRACE_RD, S_TRACE_WR, S_SWEEP, S_DONE
  } state_t;

  state_t state;

  // Memories
  gasp_pkg::cell_word_t cell_mem [DEPTH];
  logic [gasp_pkg::PATH_AW-1:0] path_mem [gasp_pkg::PATH_DEPTH];
  gasp_pkg::cell_word_t mem_rdata, mem_wdata;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic mem_we;
  logic [gasp_pkg::PATH_AW-1:0] path_rdata, path_wdata;
  logic path_we;

  // Item registers
  gasp_pkg::op_t op_q;
  logic [gasp_pkg::COORD_W-1:0] c_q, r_q, tc_q, tr_q;
  logic blk_q;
  logic [gasp_pkg::PATH_AW-1:0] sidx_q;
  logic [gasp_pkg::EXT_W-1:0] cols_reg, rows_reg, nc_q, nr_q;
  logic found_q;
  logic [gasp_pkg::PATH_AW-1:0] len_q;

  // Sweep
  logic [AW:0] sw;
  logic sw_v;
  logic [AW-1:0] sw_addr_q;

  // Scan pipeline and best candidate
  logic [gasp_pkg::COORD_W-1:0] scan_c, scan_r, p1_c, p1_r, p2_c, p2_r, bc, br;
  logic p1_v, p2_v, have;
  logic [gasp_pkg::COST_W:0] p2_f, bf;
  gasp_pkg::cell_word_t p2_word, bword;
  logic [gasp_pkg::ORDER_W-1:0] bo, next_order;

  // Expansion and trace
  logic [gasp_pkg::COST_W-1:0] g_q;
  gasp_pkg::dir_t dir;
  logic tgt_open;
  logic [gasp_pkg::COORD_W-1:0] cur_c, cur_r;
  logic [gasp_pkg::PATH_AW:0] n_q;

  // Pending result
  logic res_valid;
  logic [gasp_pkg::COORD_W-1:0] res_c, res_r;

  logic accept, in_grid, sw_issue, scan_last;
  logic nb_ok;
  logic [gasp_pkg::COORD_W-1:0] nb_c, nb_r;
  gasp_pkg::dir_t nb_back;

  function automatic logic [AW-1:0] addr_of(input logic [gasp_pkg::COORD_W-1:0] c,
                                            input logic [gasp_pkg::COORD_W-1:0] r);
    return {r[RW-1:0], c[CW-1:0]};
  endfunction

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_grid = (32'(c_q) < GRID_COLS) && (32'(r_q) < GRID_ROWS);
  assign sw_issue = !sw[AW];
  assign scan_last = ((6'(scan_c) + 6'd1) == nc_q) && ((6'(scan_r) + 6'd1) == nr_q);

  // Neighbor of the expanded cell in direction dir
  always_comb begin
    nb_c = bc;
    nb_r = br;
    nb_ok = 1'b0;
    nb_back = gasp_pkg::DIR_LEFT;
    unique case (dir)
      gasp_pkg::DIR_LEFT: begin
        nb_ok = (bc != '0);
        nb_c = bc - 5'd1;
        nb_back = gasp_pkg::DIR_RIGHT;
      end
      gasp_pkg::DIR_RIGHT: begin
        nb_ok = (6'(bc) + 6'd1) < nc_q;
        nb_c = bc + 5'd1;
        nb_back = gasp_pkg::DIR_LEFT;
      end
      gasp_pkg::DIR_UP: begin
        nb_ok = (br != '0);
        nb_r = br - 5'd1;
        nb_back = gasp_pkg::DIR_DOWN;
      end
      gasp_pkg::DIR_DOWN: begin
        nb_ok = (6'(br) + 6'd1) < nr_q;
        nb_r = br + 5'd1;
        nb_back = gasp_pkg::DIR_UP;
      end
      default: nb_ok = 1'b0;
    endcase
  end

  // Memory port control
  always_comb begin
    mem_raddr = '0;
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = mem_rdata;
    path_we = 1'b0;
    path_wdata = {cur_r, cur_c};
    case (state)
      S_INIT: begin
        mem_we = 1'b1;
        mem_waddr = sw[AW-1:0];
        mem_wdata = '0;
      end
      S_CELL_RD, S_SEARCH_RD: mem_raddr = addr_of(c_q, r_q);
      S_CELL_WR: begin
        mem_we = in_grid;
        mem_waddr = addr_of(c_q, r_q);
        if (op_q == gasp_pkg::OP_WRITE) mem_wdata.base = blk_q;
        else mem_wdata.temp = 1'b1;
      end
      S_SEARCH_WR: begin
        mem_we = 1'b1;
        mem_waddr = addr_of(c_q, r_q);
        mem_wdata.status = gasp_pkg::ST_OPEN;
        mem_wdata.cost = '0;
        mem_wdata.parent = gasp_pkg::DIR_LEFT;
        mem_wdata.order = '0;
      end
      S_SCAN: mem_raddr = addr_of(scan_c, scan_r);
      S_EXPAND: begin
        mem_we = have;
        mem_waddr = addr_of(bc, br);
        mem_wdata = bword;
        mem_wdata.status = gasp_pkg::ST_CLOSED;
      end
      S_NB_ISSUE: mem_raddr = addr_of(nb_c, nb_r);
      S_NB_EVAL: begin
        mem_waddr = addr_of(nb_c, nb_r);
        mem_wdata.cost = g_q;
        mem_wdata.parent = nb_back;
        if (!mem_rdata.base && !mem_rdata.temp) begin
          if (mem_rdata.status == gasp_pkg::ST_UNSEEN) begin
            mem_we = 1'b1;
            mem_wdata.status = gasp_pkg::ST_OPEN;
            mem_wdata.order = next_order;
          end else if (mem_rdata.status == gasp_pkg::ST_OPEN && mem_rdata.cost > g_q) begin
            mem_we = 1'b1;
          end
        end
      end
      S_TRACE_RD: mem_raddr = addr_of(cur_c, cur_r);
      S_TRACE_WR: path_we = 1'b1;
      S_SWEEP: begin
        mem_raddr = sw[AW-1:0];
        mem_we = sw_v;
        mem_waddr = sw_addr_q;
        mem_wdata.temp = 1'b0;
        mem_wdata.status = gasp_pkg::ST_UNSEEN;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) cell_mem[mem_waddr] <= mem_wdata;
    mem_rdata <= cell_mem[mem_raddr];
    if (path_we) path_mem[n_q[gasp_pkg::PATH_AW-1:0]] <= path_wdata;
    path_rdata <= path_mem[step_index];
  end

  // Scan pipeline: f in the first stage, compare in the second
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
    end else begin
      p1_v <= (state == S_SCAN);
      p2_v <= p1_v && (mem_rdata.status == gasp_pkg::ST_OPEN);
    end
    p1_c <= scan_c;
    p1_r <= scan_r;
    p2_c <= p1_c;
    p2_r <= p1_r;
    p2_word <= mem_rdata;
    p2_f <= 15'(mem_rdata.cost) + 15'(gasp_pkg::absdiff5(p1_c, tc_q))
          + 15'(gasp_pkg::absdiff5(p1_r, tr_q));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      sw <= '0;
      sw_v <= 1'b0;
      out_valid <= 1'b0;
      found_q <= 1'b0;
      len_q <= '0;
      cols_reg <= gasp_pkg::RESET_COLS;
      rows_reg <= gasp_pkg::RESET_ROWS;
      have <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gasp_pkg::CFG_COLS) cols_reg <= cfg_data;
        else rows_reg <= cfg_data;
      end
      if (state == S_DONE && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      unique case (state)
        S_INIT: begin
          sw <= sw + 1'b1;
          if (&sw[AW-1:0]) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            op_q <= gasp_pkg::op_t'(operation);
            c_q <= col;
            r_q <= row;
            blk_q <= blocked;
            tc_q <= target_col;
            tr_q <= target_row;
            sidx_q <= step_index;
            res_valid <= 1'b0;
            res_c <= '0;
            res_r <= '0;
            unique case (gasp_pkg::op_t'(operation))
              gasp_pkg::OP_WRITE, gasp_pkg::OP_OBSTACLE: state <= S_CELL_RD;
              gasp_pkg::OP_READ: state <= S_PATH_RD;
              gasp_pkg::OP_SEARCH: begin
                nc_q <= gasp_pkg::clamp_ext(cols_reg, UC_EXT);
                nr_q <= gasp_pkg::clamp_ext(rows_reg, UR_EXT);
                found_q <= 1'b0;
                len_q <= '0;
                state <= S_SEARCH_RD;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_CELL_RD: state <= S_CELL_WR;
        S_CELL_WR: state <= S_DONE;
        S_PATH_RD: begin
          if (sidx_q < len_q) begin
            res_valid <= 1'b1;
            res_c <= path_rdata[gasp_pkg::COORD_W-1:0];
            res_r <= path_rdata[2*gasp_pkg::COORD_W-1:gasp_pkg::COORD_W];
          end
          state <= S_DONE;
        end
        S_SEARCH_RD: begin
          sw <= '0;
          sw_v <= 1'b0;
          // Start or target outside the usable area: fail, still clear obstacles
          if (!((6'(c_q) < nc_q) && (6'(r_q) < nr_q) && (6'(tc_q) < nc_q)
                && (6'(tr_q) < nr_q))) begin
            state <= S_SWEEP;
          end else if (c_q == tc_q && r_q == tr_q) begin
            found_q <= 1'b1;
            state <= S_SWEEP;
          end else begin
            state <= S_SEARCH_WR;
          end
        end
        S_SEARCH_WR: begin
          next_order <= 10'd1;
          tgt_open <= 1'b0;
          have <= 1'b0;
          scan_c <= '0;
          scan_r <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if ((6'(scan_c) + 6'd1) == nc_q) begin
            scan_c <= '0;
            scan_r <= scan_r + 5'd1;
          end else begin
            scan_c <= scan_c + 5'd1;
          end
          if (scan_last) state <= S_SCAN_D1;
        end
        S_SCAN_D1: state <= S_SCAN_D2;
        S_SCAN_D2: state <= S_EXPAND;
        S_EXPAND: begin
          g_q <= bword.cost + gasp_pkg::STEP_COST;
          dir <= gasp_pkg::DIR_LEFT;
          if (have) begin
            state <= S_NB_ISSUE;
          end else begin
            state <= S_SWEEP;
          end
        end
        S_NB_ISSUE: begin
          if (nb_ok) begin
            state <= S_NB_EVAL;
          end else if (dir == gasp_pkg::DIR_DOWN) begin
            state <= S_CHECK;
          end else begin
            dir <= gasp_pkg::dir_t'(dir + 2'd1);
          end
        end
        S_NB_EVAL: begin
          if (!mem_rdata.base && !mem_rdata.temp
              && mem_rdata.status == gasp_pkg::ST_UNSEEN) begin
            next_order <= next_order + 10'd1;
            if (nb_c == tc_q && nb_r == tr_q) tgt_open <= 1'b1;
          end
          if (dir == gasp_pkg::DIR_DOWN) begin
            state <= S_CHECK;
          end else begin
            dir <= gasp_pkg::dir_t'(dir + 2'd1);
            state <= S_NB_ISSUE;
          end
        end
        S_CHECK: begin
          if (tgt_open) begin
            found_q <= 1'b1;
            cur_c <= tc_q;
            cur_r <= tr_q;
            n_q <= '0;
            state <= S_TRACE_RD;
          end else begin
            have <= 1'b0;
            scan_c <= '0;
            scan_r <= '0;
            state <= S_SCAN;
          end
        end
        S_TRACE_RD: begin
          if ((cur_c == c_q && cur_r == r_q) || n_q[gasp_pkg::PATH_AW]) begin
            len_q <= n_q[gasp_pkg::PATH_AW-1:0];
            state <= S_SWEEP;
          end else begin
            state <= S_TRACE_WR;
          end
        end
        S_TRACE_WR: begin
          n_q <= n_q + 1'b1;
          state <= S_TRACE_RD;
          // Follow the parent; stop on a pointer that leaves the area
          unique case (mem_rdata.parent)
            gasp_pkg::DIR_LEFT: begin
              if (cur_c == '0) state <= S_SWEEP;
              cur_c <= cur_c - 5'd1;
            end
            gasp_pkg::DIR_RIGHT: begin
              if ((6'(cur_c) + 6'd1) >= nc_q) state <= S_SWEEP;
              cur_c <= cur_c + 5'd1;
            end
            gasp_pkg::DIR_UP: begin
              if (cur_r == '0) state <= S_SWEEP;
              cur_r <= cur_r - 5'd1;
            end
            gasp_pkg::DIR_DOWN: begin
              if ((6'(cur_r) + 6'd1) >= nr_q) state <= S_SWEEP;
              cur_r <= cur_r + 5'd1;
            end
            default: state <= S_SWEEP;
          endcase
          len_q <= 10'(n_q + 1'b1);
        end
        S_SWEEP: begin
          sw_v <= sw_issue;
          sw_addr_q <= sw[AW-1:0];
          if (sw_issue) sw <= sw + 1'b1;
          if (!sw_issue && !sw_v) state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            found <= found_q;
            path_length <= len_q;
            step_valid <= res_valid;
            step_col <= res_c;
            step_row <= res_r;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // Keep the open cell with least f, earliest insert on a tie
      if (p2_v && (!have || p2_f < bf || (p2_f == bf && p2_word.order < bo))) begin
        have <= 1'b1;
        bf <= p2_f;
        bo <= p2_word.order;
        bc <= p2_c;
        br <= p2_r;
        bword <= p2_word;
      end
    end
  end

  a_len_needs_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> path_length == '0)
    else $error("path length without a found search");

  a_step_in_path: assert property (@(posedge clk) disable iff (rst)
    out_valid && step_valid |-> path_length != '0)
    else $error("valid step with empty path");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !mem_we && !path_we)
    else $error("memory write while idle");

  a_eval_after_issue: assert property (@(posedge clk) disable iff (rst)
    state == S_NB_EVAL |-> $past(state) == S_NB_ISSUE)
    else $error("neighbor evaluated without a read");

endmodule

/* tb/sv/grid_astar_path_search_top_tb.sv */
// Testbench for the grid path search block: directed and random items checked against a predictor.
`timescale 1ns / 1ps

module grid_astar_path_search_top_tb;

  localparam int NCOLS = 32;
  localparam int NROWS = 32;
  localparam int NCELLS = NCOLS * NROWS;

  typedef struct {
    bit       found;
    bit [9:0] len;
    bit       sv;
    bit [4:0] sc;
    bit [4:0] sr;
  } step_result_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] operation;
  logic [4:0] col, row, target_col, target_row;
  logic blocked;
  logic [9:0] step_index;
  logic out_valid;
  logic out_stall;
  logic found;
  logic [9:0] path_length;
  logic step_valid;
  logic [4:0] step_col, step_row;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [5:0] cfg_data;

  grid_astar_path_search_top #(.GRID_COLS(NCOLS), .GRID_ROWS(NROWS)) i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .col(col), .row(row), .blocked(blocked),
    .target_col(target_col), .target_row(target_row), .step_index(step_index),
    .out_valid(out_valid), .out_stall(out_stall), .found(found),
    .path_length(path_length), .step_valid(step_valid), .step_col(step_col),
    .step_row(step_row), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state
  bit                 map_blk [NCELLS];
  bit                 tmp_blk [NCELLS];
  gasp_pkg::status_t  stat [NCELLS];
  bit [13:0]          gcost [NCELLS];
  gasp_pkg::dir_t     par [NCELLS];
  bit [9:0]           ord [NCELLS];
  bit [9:0]           route [1024];
  int                 route_len;
  bit                 reached;
  bit [5:0]           cols_reg, rows_reg;

  step_result_t pending_results[$];
  int mismatches;
  int send_gap_pct;
  int stall_pct;
  int hold_cnt;
  bit hold_go;
  int ext_c, ext_r;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int clamp_extent(bit [5:0] v, int lim);
    int e;
    e = v;
    if (e < 1) e = 1;
    if (e > lim) e = lim;
    if (e > 32) e = 32;
    return e;
  endfunction

  function automatic int adiff(int a, int b);
    return a > b ? a - b : b - a;
  endfunction

  task automatic predict_search(int sc, int sr, int tc, int tr);
    int nc, nr, nxt, ci, ti, ni, cr, cc, xc, xr, f, bf, bo, c, r, n;
    bit have;
    bit [13:0] g;
    gasp_pkg::dir_t back;
    nc = clamp_extent(cols_reg, NCOLS);
    nr = clamp_extent(rows_reg, NROWS);
    nxt = 0;
    reached = 0;
    route_len = 0;
    foreach (stat[i]) stat[i] = gasp_pkg::ST_UNSEEN;
    if (sc < nc && sr < nr && tc < nc && tr < nr) begin
      if (sc == tc && sr == tr) begin
        reached = 1;
      end else begin
        ci = sr * NCOLS + sc;
        ti = tr * NCOLS + tc;
        stat[ci] = gasp_pkg::ST_OPEN;
        gcost[ci] = '0;
        par[ci] = gasp_pkg::DIR_LEFT;
        ord[ci] = nxt[9:0];
        nxt++;
        forever begin
          have = 0; bf = 0; bo = 0; cr = 0; cc = 0;
          for (r = 0; r < nr; r++)
            for (c = 0; c < nc; c++) begin
              ni = r * NCOLS + c;
              if (stat[ni] == gasp_pkg::ST_OPEN) begin
                f = gcost[ni] + adiff(c, tc) + adiff(r, tr);
                if (!have || f < bf || (f == bf && ord[ni] < bo)) begin
                  have = 1; bf = f; bo = ord[ni]; cr = r; cc = c;
                end
              end
            end
          if (!have) break;
          ci = cr * NCOLS + cc;
          g = gcost[ci] + 14'd10;
          stat[ci] = gasp_pkg::ST_CLOSED;
          for (int d = 0; d < 4; d++) begin
            xc = cc; xr = cr;
            if (d == 0) begin
              if (cc == 0) continue;
              xc = cc - 1; back = gasp_pkg::DIR_RIGHT;
            end else if (d == 1) begin
              if (cc + 1 >= nc) continue;
              xc = cc + 1; back = gasp_pkg::DIR_LEFT;
            end else if (d == 2) begin
              if (cr == 0) continue;
              xr = cr - 1; back = gasp_pkg::DIR_DOWN;
            end else begin
              if (cr + 1 >= nr) continue;
              xr = cr + 1; back = gasp_pkg::DIR_UP;
            end
            ni = xr * NCOLS + xc;
            if (map_blk[ni] || tmp_blk[ni] || stat[ni] == gasp_pkg::ST_CLOSED) continue;
            if (stat[ni] == gasp_pkg::ST_UNSEEN) begin
              stat[ni] = gasp_pkg::ST_OPEN;
              gcost[ni] = g;
              par[ni] = back;
              ord[ni] = nxt[9:0];
              nxt++;
            end else if (gcost[ni] > g) begin
              gcost[ni] = g;
              par[ni] = back;
            end
          end
          if (stat[ti] == gasp_pkg::ST_OPEN) begin
            reached = 1;
            break;
          end
        end
        if (reached) begin
          c = tc; r = tr; n = 0;
          while (!(c == sc && r == sr) && n < 1024) begin
            back = par[r * NCOLS + c];
            route[n] = {r[4:0], c[4:0]};
            n++;
            if (back == gasp_pkg::DIR_LEFT) begin
              if (c == 0) break;
              c--;
            end else if (back == gasp_pkg::DIR_RIGHT) begin
              if (c + 1 >= nc) break;
              c++;
            end else if (back == gasp_pkg::DIR_UP) begin
              if (r == 0) break;
              r--;
            end else begin
              if (r + 1 >= nr) break;
              r++;
            end
          end
          route_len = n & 10'h3ff;
        end
      end
    end
    foreach (tmp_blk[i]) tmp_blk[i] = 0;
  endtask

  task automatic predict_item(gasp_pkg::op_t op, int c, int r, bit b, int tc, int tr, int idx);
    step_result_t res;
    res.sv = 0; res.sc = 0; res.sr = 0;
    case (op)
      gasp_pkg::OP_WRITE: map_blk[r * NCOLS + c] = b;
      gasp_pkg::OP_OBSTACLE: tmp_blk[r * NCOLS + c] = 1;
      gasp_pkg::OP_SEARCH: predict_search(c, r, tc, tr);
      gasp_pkg::OP_READ: begin
        if (idx < route_len) begin
          res.sv = 1;
          res.sc = route[idx][4:0];
          res.sr = route[idx][9:5];
        end
      end
    endcase
    res.found = reached;
    res.len = route_len[9:0];
    pending_results = {pending_results, res};
  endtask

  // Call at a clock edge; returns at the edge where the item was taken, or later after a random send gap.
  task automatic send_item(gasp_pkg::op_t op, int c, int r, bit b, int tc, int tr, int idx);
    operation <= op;
    col <= c[4:0];
    row <= r[4:0];
    blocked <= b;
    target_col <= tc[4:0];
    target_row <= tr[4:0];
    step_index <= idx[9:0];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_item(op, c, r, b, tc, tr, idx);
    if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[5:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == gasp_pkg::CFG_COLS) cols_reg = val[5:0];
    else rows_reg = val[5:0];
  endtask

  task automatic set_extent(int c, int r);
    write_reg(gasp_pkg::CFG_COLS, c);
    write_reg(gasp_pkg::CFG_ROWS, r);
    ext_c = clamp_extent(c[5:0], NCOLS);
    ext_r = clamp_extent(r[5:0], NROWS);
  endtask

  task automatic read_route(int count);
    for (int i = 0; i < count; i++) send_item(gasp_pkg::OP_READ, 0, 0, 0, 0, 0, i);
  endtask

  task automatic test_reset_extent();
    send_item(gasp_pkg::OP_SEARCH, 0, 0, 0, 2, 1, 0);
    read_route(4);
    send_item(gasp_pkg::OP_SEARCH, 0, 0, 0, 24, 0, 0);
    send_item(gasp_pkg::OP_SEARCH, 23, 24, 0, 22, 24, 0);
    read_route(2);
  endtask

  task automatic test_special_cases();
    set_extent(4, 4);
    send_item(gasp_pkg::OP_WRITE, 31, 31, 1, 0, 0, 0);
    send_item(gasp_pkg::OP_WRITE, 31, 31, 0, 0, 0, 0);
    send_item(gasp_pkg::OP_SEARCH, 2, 2, 0, 2, 2, 0);
    send_item(gasp_pkg::OP_READ, 0, 0, 0, 0, 0, 1023);
    send_item(gasp_pkg::OP_WRITE, 3, 3, 1, 0, 0, 0);
    send_item(gasp_pkg::OP_SEARCH, 0, 0, 0, 3, 3, 0);
    send_item(gasp_pkg::OP_WRITE, 3, 3, 0, 0, 0, 0);
    send_item(gasp_pkg::OP_WRITE, 0, 0, 1, 0, 0, 0);
    send_item(gasp_pkg::OP_OBSTACLE, 1, 0, 0, 0, 0, 0);
    send_item(gasp_pkg::OP_SEARCH, 0, 0, 0, 3, 3, 0);
    read_route(7);
    send_item(gasp_pkg::OP_SEARCH, 0, 0, 0, 3, 3, 0);
    send_item(gasp_pkg::OP_WRITE, 0, 0, 0, 0, 0, 0);
    send_item(gasp_pkg::OP_SEARCH, 4, 0, 0, 1, 1, 0);
  endtask

  task automatic test_extent_limits();
    set_extent(0, 0);
    send_item(gasp_pkg::OP_SEARCH, 0, 0, 0, 0, 0, 0);
    send_item(gasp_pkg::OP_SEARCH, 0, 0, 0, 1, 0, 0);
    set_extent(63, 63);
    send_item(gasp_pkg::OP_SEARCH, 31, 31, 0, 30, 31, 0);
    read_route(2);
    send_item(gasp_pkg::OP_SEARCH, 0, 0, 0, 0, 1, 0);
    send_item(gasp_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
    set_extent(32, 1);
    send_item(gasp_pkg::OP_SEARCH, 31, 0, 0, 29, 0, 0);
    read_route(3);
  endtask

  task automatic send_random_item();
    int pick, c, r, tc, tr, idx;
    bit inside_ext;
    pick = $urandom_range(99);
    inside_ext = $urandom_range(99) < 85;
    c = inside_ext ? $urandom_range(ext_c - 1) : $urandom_range(31);
    r = inside_ext ? $urandom_range(ext_r - 1) : $urandom_range(31);
    tc = inside_ext ? $urandom_range(ext_c - 1) : $urandom_range(31);
    tr = inside_ext ? $urandom_range(ext_r - 1) : $urandom_range(31);
    idx = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(route_len + 1);
    if (pick < 30) send_item(gasp_pkg::OP_WRITE, c, r, $urandom_range(99) < 35, 0, 0, 0);
    else if (pick < 42) send_item(gasp_pkg::OP_OBSTACLE, c, r, $urandom_range(1), 0, 0, 0);
    else if (pick < 65) send_item(gasp_pkg::OP_SEARCH, c, r, $urandom_range(1), tc, tr, idx);
    else send_item(gasp_pkg::OP_READ, c, r, $urandom_range(1), tc, tr, idx);
  endtask

  task automatic test_random_phase(int c, int r, int gap, int stall, int count);
    set_extent(c, r);
    send_gap_pct = gap;
    stall_pct = stall;
    repeat (count) send_random_item();
  endtask

  task automatic test_backpressure();
    send_gap_pct = 0;
    stall_pct = 0;
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    for (int i = 0; i < 20; i++) send_item(gasp_pkg::OP_READ, 0, 0, 0, 0, 0, i % 4);
    // wait for everything, then send again from an empty block
    wait_drained();
    send_item(gasp_pkg::OP_SEARCH, 0, 0, 0, 2, 2, 0);
    read_route(3);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_go) begin
      out_stall <= 1'b1;
      hold_cnt <= 300;
    end else if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else begin
      out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    step_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        exp_res = pending_results.pop_front();
        if (found !== exp_res.found || path_length !== exp_res.len ||
            step_valid !== exp_res.sv || step_col !== exp_res.sc ||
            step_row !== exp_res.sr) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                     $realtime, exp_res.found, exp_res.len, exp_res.sv, exp_res.sc,
                     exp_res.sr, found, path_length, step_valid, step_col, step_row);
        end
      end
    end
  end

  initial begin
    mismatches = 0;
    send_gap_pct = 0;
    stall_pct = 0;
    hold_go = 0;
    route_len = 0;
    reached = 0;
    cols_reg = 6'd24;
    rows_reg = 6'd25;
    ext_c = 24;
    ext_r = 25;
    foreach (map_blk[i]) begin
      map_blk[i] = 0;
      tmp_blk[i] = 0;
      stat[i] = gasp_pkg::ST_UNSEEN;
    end
    rst = 1'b1;
    in_valid = 1'b0;
    operation = '0;
    col = '0;
    row = '0;
    blocked = 1'b0;
    target_col = '0;
    target_row = '0;
    step_index = '0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_extent();
    test_special_cases();
    test_extent_limits();
    test_backpressure();
    test_random_phase(5, 5, 0, 0, 19);
    test_random_phase(6, 4, 61, 0, 19);
    test_random_phase(3, 7, 0, 61, 19);
    test_random_phase($urandom_range(2, 7), $urandom_range(2, 7), 7, 7, 19);
    stall_pct = 0;
    wait_drained();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/gasp_pkg.sv
rtl/grid_astar_path_search_top.sv
tb/sv/grid_astar_path_search_top_tb.sv
